@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the frequency meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle; the check is off while reset is low.
`define EWFM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define EWFM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ewfm_pkg.sv @@
// Types and constants shared by the frequency meter modules.
`default_nettype none

package ewfm_pkg;

    // Field widths.
    localparam int STAMP_W  = 32;
    localparam int FREQ_W   = 48;
    localparam int HZ_W     = 27;
    localparam int FRAC_W   = 16;
    // Width of the window length as it enters the multiplier (covers up to 255).
    localparam int WIN_W    = 8;
    localparam int PROD_W   = WIN_W + HZ_W;
    localparam int NUM_W    = PROD_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TIMER_HZ_IDX = 1'b0;

    localparam logic [HZ_W-1:0]   TIMER_HZ_RESET = HZ_W'(1000000);
    localparam logic [FREQ_W-1:0] FREQ_MAX       = {FREQ_W{1'b1}};

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_EDGE = 2'd0,
        KIND_ARM  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // Input word.
    typedef struct packed {
        kind_t              kind;
        logic [STAMP_W-1:0] edge_time;
    } in_item_t;

    // Result word.
    typedef struct packed {
        logic               ready_res;
        logic               is_reading;
        logic [STAMP_W-1:0] period_ticks;
        logic [FREQ_W-1:0]  frequency_q16;
        logic               zero_period;
    } out_item_t;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   dividend;
        logic [STAMP_W-1:0] divisor;
    } div_req_t;

    // Status from the shared divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/edge_window_frequency_meter_top.sv @@
// Top level of the edge window frequency meter: sequencer, ring control and register port.
`default_nettype none

// Reciprocal frequency counter over a window of WINDOW_PERIODS periods. Each input
// word is a falling edge with its timestamp, an arm command or a read request, and
// each one yields exactly one result word. Edge, arm and unused kinds go from the
// accepting state to the done state, which loads the output register. A read passes
// through the accepting state, two reads of the timestamp ring through its one read
// port, the span and window-times-rate product, the start of the shared restoring
// divider, 51 divider steps of one quotient bit each, which set the read rate, the
// quotient collection and the output register load. A zero span skips the divider.
// The block takes one word at a time and accepts the next one once the previous
// result is in the output register; a result held by the receiver stalls the input.
// The timestamp ring needs no clearing pass; entries never written since reset read
// as zero. timer_hz is written through the register port at byte address 0; the user
// must write it only while the block is idle, which the block itself does not enforce.

`include "assert_macros.svh"

module edge_window_frequency_meter_top #(
    parameter int WINDOW_PERIODS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input channel.
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire ewfm_pkg::in_item_t              s_data,
    // Result channel.
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      ewfm_pkg::out_item_t             m_data,
    // Register port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ewfm_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [ewfm_pkg::PDATA_W-1:0]    pwdata,
    output      logic [ewfm_pkg::PDATA_W-1:0]    prdata,
    output      logic                            pready
);

    import ewfm_pkg::*;

    localparam int SLOT = WINDOW_PERIODS + 1;
    localparam int AW   = (SLOT > 1) ? $clog2(SLOT) : 1;
    localparam int LW   = $clog2(SLOT + 1);

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_LOADING  = 4'b0010,
        MODE_COUNTING = 4'b0100,
        MODE_READY    = 4'b1000
    } mode_t;

    typedef enum logic [5:0] {
        SEQ_IDLE   = 6'b000001,
        SEQ_RD_OLD = 6'b000010,
        SEQ_RD_NEW = 6'b000100,
        SEQ_START  = 6'b001000,
        SEQ_DIV    = 6'b010000,
        SEQ_DONE   = 6'b100000
    } seq_t;

    seq_t              seq_reg, seq_next;
    mode_t             mode_reg, mode_next;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic [AW-1:0]     newest_reg, newest_next;
    logic [LW-1:0]     load_count_reg, load_count_next;
    logic [HZ_W-1:0]   timer_hz_reg;
    logic [STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    logic [STAMP_W-1:0] span_reg, span_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    out_item_t         res_reg, res_next;
    out_item_t         m_data_reg;
    logic              m_valid_reg, m_valid_next;

    logic              accept;
    logic              out_free;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [STAMP_W-1:0] rd_data;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        return (i == AW'(SLOT - 1)) ? '0 : i + 1'b1;
    endfunction

    assign s_ready  = (seq_reg == SEQ_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Timestamp ring.
    ewfm_stamp_ram #(
        .DEPTH (SLOT),
        .AW    (AW),
        .DW    (STAMP_W)
    ) u_stamp_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.edge_time),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared divider.
    ewfm_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer, ring bookkeeping and result assembly.
    always_comb begin
        seq_next        = seq_reg;
        mode_next       = mode_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        load_count_next = load_count_reg;
        old_stamp_next  = old_stamp_reg;
        span_next       = span_reg;
        prod_next       = prod_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = '0;
        rd_en           = 1'b0;
        rd_addr         = oldest_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {prod_reg, {FRAC_W{1'b0}}};
        div_req.divisor  = span_reg;

        case (seq_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    seq_next = SEQ_DONE;
                    case (s_data.kind)
                        KIND_EDGE: begin
                            case (mode_reg)
                                MODE_LOADING: begin
                                    if (load_count_reg < LW'(SLOT)) begin
                                        wr_en           = 1'b1;
                                        wr_addr         = load_count_reg[AW-1:0];
                                        load_count_next = load_count_reg + 1'b1;
                                    end
                                    if (load_count_next >= LW'(SLOT)) begin
                                        mode_next = MODE_READY;
                                    end
                                end
                                MODE_COUNTING, MODE_READY: begin
                                    oldest_next = next_slot(oldest_reg);
                                    newest_next = next_slot(newest_reg);
                                    wr_en       = 1'b1;
                                    wr_addr     = newest_next;
                                    mode_next   = MODE_READY;
                                end
                                default: begin
                                end
                            endcase
                        end
                        KIND_ARM: begin
                            oldest_next     = '0;
                            newest_next     = AW'(WINDOW_PERIODS);
                            load_count_next = '0;
                            mode_next       = MODE_LOADING;
                        end
                        KIND_READ: begin
                            // Fetch the oldest stamp first; the read puts the ring into counting mode.
                            rd_en     = 1'b1;
                            rd_addr   = oldest_reg;
                            mode_next = MODE_COUNTING;
                            seq_next  = SEQ_RD_OLD;
                        end
                        default: begin
                        end
                    endcase
                    res_next               = '0;
                    res_next.ready_res     = (mode_next == MODE_READY);
                end
            end
            SEQ_RD_OLD: begin
                old_stamp_next = rd_data;
                rd_en          = 1'b1;
                rd_addr        = newest_reg;
                seq_next       = SEQ_RD_NEW;
            end
            SEQ_RD_NEW: begin
                // Wrapped span and the scaled window rate.
                span_next = rd_data - old_stamp_reg;
                prod_next = PROD_W'(WIN_W'(WINDOW_PERIODS)) * PROD_W'(timer_hz_reg);
                seq_next  = SEQ_START;
            end
            SEQ_START: begin
                res_next              = '0;
                res_next.is_reading   = 1'b1;
                res_next.period_ticks = span_reg;
                if (span_reg == '0) begin
                    res_next.zero_period   = 1'b1;
                    res_next.frequency_q16 = FREQ_MAX;
                    seq_next               = SEQ_DONE;
                end else begin
                    div_req.start = 1'b1;
                    seq_next      = SEQ_DIV;
                end
            end
            SEQ_DIV: begin
                // Saturate quotients that do not fit the result field.
                if (div_rsp.done) begin
                    if (div_rsp.quotient[NUM_W-1:FREQ_W] != '0) begin
                        res_next.frequency_q16 = FREQ_MAX;
                    end else begin
                        res_next.frequency_q16 = div_rsp.quotient[FREQ_W-1:0];
                    end
                    seq_next = SEQ_DONE;
                end
            end
            SEQ_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    seq_next     = SEQ_IDLE;
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= SEQ_IDLE;
            mode_reg       <= MODE_IDLE;
            oldest_reg     <= '0;
            newest_reg     <= '0;
            load_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            mode_reg       <= mode_next;
            oldest_reg     <= oldest_next;
            newest_reg     <= newest_next;
            load_count_reg <= load_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working registers and the output word.
    always_ff @(posedge aclk) begin
        old_stamp_reg <= old_stamp_next;
        span_reg      <= span_next;
        prod_reg      <= prod_next;
        res_reg       <= res_next;
        if (seq_reg == SEQ_DONE && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Register port: timer_hz at byte address 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_hz_reg <= TIMER_HZ_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMER_HZ_IDX) begin
            timer_hz_reg <= pwdata[HZ_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMER_HZ_IDX) ? PDATA_W'(timer_hz_reg) : '0;

    // Checks on the sequencer and the ring bookkeeping.
    `EWFM_ASSERT_IMP(a_no_accept_while_div, aclk, aresetn, div_rsp.busy, !s_ready, "input taken while dividing")
    `EWFM_ASSERT_IMP(a_read_not_ready, aclk, aresetn, m_valid && m_data.is_reading, !m_data.ready_res, "read result flagged ready")
    `EWFM_ASSERT_IMP(a_zero_span_max, aclk, aresetn, m_valid && m_data.zero_period, m_data.is_reading && m_data.frequency_q16 == FREQ_MAX && m_data.period_ticks == '0, "zero span result inconsistent")
    `EWFM_ASSERT_IMP(a_load_bound, aclk, aresetn, 1'b1, load_count_reg <= LW'(SLOT) && oldest_reg < AW'(SLOT) && newest_reg < AW'(SLOT), "ring index out of range")
    `EWFM_ASSERT_NXT(a_div_done_to_result, aclk, aresetn, div_rsp.done, seq_reg == SEQ_DONE && res_reg.is_reading, "divider result not collected")

endmodule

`default_nettype wire

@@ rtl/ewfm_stamp_ram.sv @@
// Timestamp ring storage with one write port, one registered read port and valid bits.
`default_nettype none

module ewfm_stamp_ram #(
    parameter int DEPTH = 17,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output      logic [DW-1:0] rd_data
);

    logic [DW-1:0]    mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rd_data_reg;

    // Storage array; written entries are marked valid.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Valid bits make never-written entries read as zero after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/ewfm_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module ewfm_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ewfm_pkg::div_req_t req,
    output      ewfm_pkg::div_rsp_t rsp
);

    import ewfm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [STAMP_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [STAMP_W-1:0]   dvsr_reg, dvsr_next;
    logic [STAMP_W:0]     shifted;
    logic [STAMP_W+1:0]   diff;

    // One step: shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvsr_next = req.divisor;
        end else if (busy_reg) begin
            if (!diff[STAMP_W+1]) begin
                rem_next = diff[STAMP_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[STAMP_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire
